// ----- design/xcfr_pkg.sv -----
// Shared types and constants for the XOR-checked frame receiver.
// No dependencies; the front, queue, back and top files import this package.
package xcfr_pkg;

  // lengths cover the full MAX_LEN range (7 bits, up to 127)
  localparam int LEN_W     = 7;
  localparam int Q_DEPTH   = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 1'b1;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  // read command from front to back
  typedef struct packed {
    logic             avail;
    logic             bank;
    logic [LEN_W-1:0] len;
  } rd_cmd_t;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_LENGTH = 5'b00010,
    PH_DATA   = 5'b00100,
    PH_CHECK  = 5'b01000,
    PH_TAIL   = 5'b10000
  } phase_t;

endpackage

// ----- design/xcfr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module xcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/xcfr_front.sv -----
// Front end: config registers, frame parser, payload writes, read classification.
// Depends on xcfr_pkg; writes payload into the banked RAM, pushes read commands.
module xcfr_front #(
  parameter int MAX_LEN = 32,
  parameter int IW      = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [xcfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            operation,
  input  logic [7:0]                      rx_byte,
  input  logic                            q_full,
  input  logic                            rd_busy,
  output logic                            push,
  output xcfr_pkg::rd_cmd_t               push_cmd,
  output logic                            ram_we,
  output logic [IW:0]                     ram_waddr,
  output logic [7:0]                      ram_wdata
);
  import xcfr_pkg::*;

  phase_t           phase;
  logic [7:0]       hdr;
  logic [7:0]       tl;
  logic [LEN_W-1:0] exp_len;
  logic [LEN_W-1:0] cnt;
  logic [LEN_W-1:0] cnt_inc;
  logic [7:0]       run_xor;
  logic [7:0]       chk;
  logic [LEN_W-1:0] lat_len;
  logic             lat_bank;
  logic             ready_flag;
  logic             accept;

  // payload writes go to the bank not holding the latest frame; hold them
  // off while any read is still pending, since that bank may be in use
  assign in_ready  = !q_full && !((phase == PH_DATA) && rd_busy);
  assign accept    = in_valid && in_ready;
  assign cnt_inc   = cnt + LEN_W'(1);

  assign push      = accept && (operation == OP_READ);
  assign push_cmd  = '{avail: ready_flag, bank: lat_bank,
                       len: ready_flag ? lat_len : '0};

  assign ram_we    = accept && (operation == OP_BYTE) && (phase == PH_DATA);
  assign ram_waddr = {~lat_bank, cnt[IW-1:0]};
  assign ram_wdata = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      hdr        <= 8'hFF;
      tl         <= 8'hFE;
      exp_len    <= '0;
      cnt        <= '0;
      run_xor    <= '0;
      chk        <= '0;
      lat_len    <= '0;
      lat_bank   <= 1'b0;
      ready_flag <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HEADER: hdr <= cfg_data;
          REG_TAIL:   tl  <= cfg_data;
          default: ;
        endcase
      end
      if (push) begin
        ready_flag <= 1'b0;
      end
      if (accept && (operation == OP_BYTE)) begin
        case (phase)
          PH_HEADER: begin
            if (rx_byte == hdr) begin
              phase   <= PH_LENGTH;
              run_xor <= hdr;
              cnt     <= '0;
            end
          end
          PH_LENGTH: begin
            if (rx_byte > 8'(MAX_LEN)) begin
              phase <= PH_HEADER;
            end else begin
              exp_len <= LEN_W'(rx_byte);
              cnt     <= '0;
              run_xor <= run_xor ^ rx_byte;
              phase   <= (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
            end
          end
          PH_DATA: begin
            cnt     <= cnt_inc;
            run_xor <= run_xor ^ rx_byte;
            if (cnt_inc >= exp_len) begin
              phase <= PH_CHECK;
            end
          end
          PH_CHECK: begin
            chk   <= rx_byte;
            phase <= PH_TAIL;
          end
          PH_TAIL: begin
            // commit = swap banks
            if ((rx_byte == tl) && (chk == run_xor)) begin
              lat_len    <= exp_len;
              lat_bank   <= ~lat_bank;
              ready_flag <= 1'b1;
            end
            if (rx_byte == hdr) begin
              phase   <= PH_LENGTH;
              run_xor <= hdr;
              cnt     <= '0;
            end else begin
              phase <= PH_HEADER;
            end
          end
          default: phase <= PH_HEADER;
        endcase
      end
    end
  end

endmodule

// ----- design/xcfr_queue.sv -----
// Short FIFO of read commands between front and back.
// Depends on xcfr_pkg for the command type and depth.
module xcfr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  xcfr_pkg::rd_cmd_t push_cmd,
  output logic              full,
  output logic              q_valid,
  output xcfr_pkg::rd_cmd_t q_cmd,
  input  logic              pop
);
  import xcfr_pkg::*;

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  rd_cmd_t        entries [Q_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_cmd;
        wr_ptr <= (wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- design/xcfr_back.sv -----
// Back end: executes read commands, streams payload words from RAM (or one bare
// word for nothing new or an empty frame) into the output register. Depends on xcfr_pkg; reads the banked payload RAM.
module xcfr_back #(
  parameter int IW = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  xcfr_pkg::rd_cmd_t q_cmd,
  output logic              pop,
  output logic              busy,
  output logic              ram_re,
  output logic [IW:0]       ram_raddr,
  input  logic [7:0]        ram_rdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              frame_available,
  output logic [5:0]        frame_length,
  output logic              has_data,
  output logic [4:0]        byte_index,
  output logic [7:0]        data_byte,
  output logic              last
);
  import xcfr_pkg::*;

  logic             active;
  logic             flight;
  logic             bank;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] idx;
  logic [LEN_W-1:0] rd_idx;
  logic             out_free;
  logic             last_hit;
  logic             load_word;

  assign out_free  = !out_valid || out_ready;
  assign ram_re    = active && !flight && out_free;
  assign ram_raddr = {bank, idx[IW-1:0]};
  assign pop       = !active && !flight && q_valid && out_free;
  assign busy      = active || flight;
  assign last_hit  = ((rd_idx + LEN_W'(1)) == len);
  // output register takes a new word this cycle
  assign load_word = flight || (pop && !(q_cmd.avail && (q_cmd.len != '0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      flight    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !load_word) begin
        out_valid <= 1'b0;
      end
      if (flight) begin
        // RAM data lands; output register was freed when the read issued
        flight          <= 1'b0;
        out_valid       <= 1'b1;
        frame_available <= 1'b1;
        frame_length    <= len[5:0];
        has_data        <= 1'b1;
        byte_index      <= rd_idx[4:0];
        data_byte       <= ram_rdata;
        last            <= last_hit;
        if (last_hit) begin
          active <= 1'b0;
        end
      end else if (ram_re) begin
        flight <= 1'b1;
        rd_idx <= idx;
        idx    <= idx + LEN_W'(1);
      end else if (pop) begin
        if (q_cmd.avail && (q_cmd.len != '0)) begin
          active <= 1'b1;
          bank   <= q_cmd.bank;
          len    <= q_cmd.len;
          idx    <= '0;
        end else begin
          // nothing new, or an empty frame: single word
          out_valid       <= 1'b1;
          frame_available <= q_cmd.avail;
          frame_length    <= '0;
          has_data        <= 1'b0;
          byte_index      <= '0;
          data_byte       <= '0;
          last            <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/xor_checked_frame_receiver.sv -----
// Top level of the XOR-checked frame receiver: front parser, command queue,
// back streamer and two-bank payload RAM. Depends on xcfr_pkg and the front, queue, RAM and back modules.
//
// A received byte (operation 0) gives no output word.
// A read (operation 1) gives one output word, or one word per payload byte of the
// latest frame; the RAM read is registered, and the back end issues the next payload
// read only after the previous word has reached the output register. While the
// parser expects payload bytes, every input word (payload byte or read) is held
// off (in_ready low) as long as a read is still queued or streaming, since both
// banks of the payload RAM may be involved; header, length, check and tail bytes
// are never held off this way. Any input word is also held off while the
// two-entry read queue is full.
// A good frame is committed by swapping RAM banks, so no copy pass is needed.
// There is no clearing pass after reset.
module xor_checked_frame_receiver #(
  parameter int MAX_LEN = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [xcfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           operation,
  input  logic [7:0]                     rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           frame_available,
  output logic [5:0]                     frame_length,
  output logic                           has_data,
  output logic [4:0]                     byte_index,
  output logic [7:0]                     data_byte,
  output logic                           last
);
  import xcfr_pkg::*;

  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic        q_full;
  logic        q_valid;
  logic        push;
  logic        pop;
  logic        back_busy;
  logic        rd_busy;
  rd_cmd_t     push_cmd;
  rd_cmd_t     q_cmd;
  logic        ram_we;
  logic [IW:0] ram_waddr;
  logic [7:0]  ram_wdata;
  logic        ram_re;
  logic [IW:0] ram_raddr;
  logic [7:0]  ram_rdata;

  assign rd_busy = q_valid || back_busy;

  xcfr_front #(.MAX_LEN(MAX_LEN), .IW(IW)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .operation, .rx_byte,
    .q_full, .rd_busy, .push, .push_cmd,
    .ram_we, .ram_waddr, .ram_wdata
  );

  xcfr_queue u_queue (
    .clk, .rst, .push, .push_cmd, .full(q_full), .q_valid, .q_cmd, .pop
  );

  xcfr_ram #(.WIDTH(8), .DEPTH(2 * (2 ** IW))) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  xcfr_back #(.IW(IW)) u_back (
    .clk, .rst, .q_valid, .q_cmd, .pop, .busy(back_busy),
    .ram_re, .ram_raddr, .ram_rdata,
    .out_valid, .out_ready, .frame_available, .frame_length,
    .has_data, .byte_index, .data_byte, .last
  );

endmodule

// ----- design/xcfr_checker.sv -----
// Port-level checks for the frame receiver output stream, bound to the top.
// Depends on xor_checked_frame_receiver port names.
module xcfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       frame_available,
  input logic [5:0] frame_length,
  input logic       has_data,
  input logic [4:0] byte_index,
  input logic [7:0] data_byte,
  input logic       last
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(last)
      && $stable(byte_index) && $stable(has_data))
    else $error("output word changed while stalled");

  // "nothing new" word is a bare terminator
  a_no_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_available |-> last && !has_data && (frame_length == 6'd0))
    else $error("nothing-new word malformed");

  // words without payload are single-word replies
  a_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_data |-> last && (byte_index == 5'd0) && (data_byte == 8'd0))
    else $error("empty word malformed");

  // final payload word sits at length - 1
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_data && last |-> frame_available
      && (byte_index == 5'(frame_length - 6'd1)))
    else $error("last payload word at wrong index");

endmodule

bind xor_checked_frame_receiver xcfr_checker u_chk (.*);
